// File: design/indexed_insert_delete_array_assert.svh
// Assertion macros used by the top level of the indexed insert/delete array.
`ifndef INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the indexed insert/delete array");

// The consequent must hold in the cycle after the antecedent.
`define IIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in the indexed insert/delete array");

`endif

// File: design/iida_pkg.sv
// Package with sizes, codes and beat types of the indexed insert/delete array.
package iida_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int REQ_TYPE_W = 3;
  localparam int INDEX_W    = 5;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int LENGTH_W   = 5;
  localparam int STATUS_W   = 2;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_READ   = 3'd0,
    REQ_SET    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INDEX_W-1:0]    index;
    logic [VALUE_W-1:0]    value;
    logic [COUNT_W-1:0]    count;
    logic                  last_in_run;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [LENGTH_W-1:0] length_now;
    logic [STATUS_W-1:0] status;
    logic                run_done;
  } result_t;

  typedef struct packed {
    logic accept;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic multi;
    logic last;
  } stat_t;

  function automatic word_t word_from_value(logic [VALUE_W-1:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    return v64[WORD_BITS-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] value_from_word(word_t w);
    logic [63:0] w64;
    w64 = 64'(w);
    return w64[VALUE_W-1:0];
  endfunction

endpackage

// File: design/iida_ctrl.sv
// Controller state machine of the indexed insert/delete array.
module iida_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  iida_pkg::stat_t stat_i,
  output iida_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    cmd_o.accept = start_i && (state_q == S_IDLE);
    cmd_o.step   = (state_q == S_SHIFT);
  end

  assign busy_o = (state_q == S_SHIFT);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (stat_i.multi) begin
              state_q <= S_SHIFT;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          if (stat_i.last) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/iida_dp.sv
// Datapath of the indexed insert/delete array: element cells, length and result.
module iida_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iida_pkg::req_t     req_i,
  input  iida_pkg::cmd_t     cmd_i,
  output iida_pkg::stat_t    stat_o,
  output iida_pkg::result_t  result_o
);

  iida_pkg::word_t elem_q [iida_pkg::DEPTH];
  iida_pkg::word_t elem_d [iida_pkg::DEPTH];

  logic [iida_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic [iida_pkg::ADDR_W-1:0]   idx_q;
  logic [iida_pkg::CNT_W-1:0]    rem_q;
  logic [iida_pkg::VALUE_W-1:0]  rd_q;
  logic [iida_pkg::STATUS_W-1:0] st_q;
  logic                          run_q;

  logic [iida_pkg::CMP_W-1:0]    idx_c, cnt_c, fill_c, depth_c;
  logic [iida_pkg::ADDR_W-1:0]   widx;
  iida_pkg::word_t               word;
  logic [iida_pkg::VALUE_W-1:0]  rd_d;
  logic [iida_pkg::STATUS_W-1:0] st_d;
  logic                          run_d;
  logic                          wr_set, wr_ins, grow, do_clear, multi;

  always_comb begin
    idx_c   = iida_pkg::CMP_W'(req_i.index);
    cnt_c   = iida_pkg::CMP_W'(req_i.count);
    fill_c  = iida_pkg::CMP_W'(fill_q);
    depth_c = iida_pkg::CMP_W'(iida_pkg::DEPTH);
    widx    = idx_c[iida_pkg::ADDR_W-1:0];
    word    = iida_pkg::word_from_value(req_i.value);
    rd_d     = '0;
    st_d     = iida_pkg::ST_OK;
    run_d    = 1'b0;
    wr_set   = 1'b0;
    wr_ins   = 1'b0;
    grow     = 1'b0;
    do_clear = 1'b0;
    multi    = 1'b0;
    unique case (req_i.req_type)
      iida_pkg::REQ_READ: begin
        if (idx_c < fill_c) begin
          rd_d = iida_pkg::value_from_word(elem_q[widx]);
        end else begin
          st_d = iida_pkg::ST_RANGE;
        end
      end
      iida_pkg::REQ_SET: begin
        if (idx_c < fill_c) begin
          wr_set = 1'b1;
        end else if (idx_c == fill_c) begin
          if (fill_c >= depth_c) begin
            st_d = iida_pkg::ST_FULL;
          end else begin
            wr_set = 1'b1;
            grow   = 1'b1;
          end
        end else begin
          st_d = iida_pkg::ST_RANGE;
        end
      end
      iida_pkg::REQ_INSERT: begin
        run_d = req_i.last_in_run;
        if (idx_c > fill_c) begin
          st_d = iida_pkg::ST_RANGE;
        end else if (fill_c >= depth_c) begin
          st_d = iida_pkg::ST_FULL;
        end else begin
          wr_ins = 1'b1;
          grow   = 1'b1;
        end
      end
      iida_pkg::REQ_REMOVE: begin
        if (idx_c + cnt_c > fill_c) begin
          st_d = iida_pkg::ST_RANGE;
        end else begin
          multi = (cnt_c != '0);
        end
      end
      iida_pkg::REQ_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
        st_d = iida_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    elem_d = elem_q;
    fill_d = fill_q;
    if (cmd_i.accept) begin
      if (wr_ins) begin
        for (int i = 1; i < iida_pkg::DEPTH; i++) begin
          if (iida_pkg::CMP_W'(i) > idx_c) begin
            elem_d[i] = elem_q[i-1];
          end
        end
      end
      if (wr_set || wr_ins) begin
        elem_d[widx] = word;
      end
      if (grow) begin
        fill_d = fill_q + 1'b1;
      end else if (do_clear) begin
        fill_d = '0;
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < iida_pkg::DEPTH - 1; i++) begin
        if (iida_pkg::ADDR_W'(i) >= idx_q) begin
          elem_d[i] = elem_q[i+1];
        end
      end
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (cmd_i.accept) begin
      rd_q  <= rd_d;
      st_q  <= st_d;
      run_q <= run_d;
      idx_q <= widx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q  <= '0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.accept) begin
        rem_q <= cnt_c[iida_pkg::CNT_W-1:0];
      end else if (cmd_i.step) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.multi = multi;
    stat_o.last  = (rem_q == iida_pkg::CNT_W'(1));
  end

  always_comb begin
    result_o.read_value = rd_q;
    result_o.length_now = iida_pkg::LENGTH_W'(fill_q);
    result_o.status     = st_q;
    result_o.run_done   = run_q;
  end

endmodule

// File: design/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array: controller, datapath and checks.
//
// A request beat is taken at a rising edge where start_i is high and busy_o
// is low; req_i carries the request type, index, value, remove count and
// the last-in-run mark. Every request returns exactly one result beat on
// result_o, marked by done_o for a single cycle, and the receiver cannot
// hold it off.
// Read, set or append, insert, clear and failed requests give their result
// one cycle after the request beat, and busy_o stays low, so one request
// per cycle is accepted.
// A remove of count elements that passes the bounds check shifts the tail
// down one position per cycle: busy_o is high for count cycles and the
// result appears count + 1 cycles after the request beat.
// A new request may be accepted in the cycle that shows a result.
// Reset empties the array; element words are not cleared and cannot be
// read before they are written.
`include "indexed_insert_delete_array_assert.svh"

module indexed_insert_delete_array (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  iida_pkg::req_t     req_i,
  output logic               busy_o,
  output logic               done_o,
  output iida_pkg::result_t  result_o
);

  iida_pkg::cmd_t  cmd;
  iida_pkg::stat_t stat;

  iida_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  iida_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

  `IIDA_ASSERT_SAME(a_no_result_while_busy, clk_i, rst_ni, done_o, !busy_o)
  `IIDA_ASSERT_NEXT(a_single_cycle_result, clk_i, rst_ni, start_i && !busy_o && (req_i.req_type != iida_pkg::REQ_REMOVE), done_o && !busy_o)
  `IIDA_ASSERT_SAME(a_busy_after_request, clk_i, rst_ni, $rose(busy_o), $past(start_i) && !done_o)
  `IIDA_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, start_i && !busy_o && (req_i.req_type == iida_pkg::REQ_CLEAR), result_o.length_now == '0)

endmodule
